// ===== src/grs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_pkg: shared definitions for the grouped run statistics block
// Fixed field widths, command codes and sequencer state types.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int KEY_BITS  = 64;
  localparam int WSUM_BITS = 64;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_M,
    S_WAIT_M,
    S_DIV_V,
    S_WAIT_V,
    S_EMIT,
    S_MUL_M,
    S_MUL_V,
    S_APPLY
  } grs_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_ITER
  } div_state_t;

endpackage

// ===== src/grs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_if: record and group channels
// Valid/ready channels carrying one record request and one finished group.
// ----------------------------------------------------------------------------
interface grs_in_if import grs_pkg::*; #(
  parameter int YEAR_BITS  = 12,
  parameter int COUNT_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [KEY_BITS-1:0]   record_key;
  logic [YEAR_BITS-1:0]  record_year;
  logic [COUNT_BITS-1:0] record_matches;
  logic [COUNT_BITS-1:0] record_volumes;

  modport source (
    output valid, command, record_key, record_year, record_matches, record_volumes,
    input  ready
  );
  modport sink (
    input  valid, command, record_key, record_year, record_matches, record_volumes,
    output ready
  );
endinterface

interface grs_out_if import grs_pkg::*; #(
  parameter int YEAR_BITS          = 12,
  parameter int COUNT_BITS         = 32,
  parameter int MEAN_FRACTION_BITS = 8
) ();
  logic                                   valid;
  logic                                   ready;
  logic [KEY_BITS-1:0]                    group_key;
  logic [COUNT_BITS-1:0]                  group_years;
  logic [COUNT_BITS-1:0]                  group_match_total;
  logic [COUNT_BITS-1:0]                  group_volume_total;
  logic [YEAR_BITS+MEAN_FRACTION_BITS-1:0] mean_year_by_match;
  logic [YEAR_BITS+MEAN_FRACTION_BITS-1:0] mean_year_by_volume;
  logic [YEAR_BITS-1:0]                   latest_year;
  logic [YEAR_BITS-1:0]                   earliest_year;
  logic [COUNT_BITS-1:0]                  peak_matches;
  logic [COUNT_BITS-1:0]                  least_matches;
  logic [COUNT_BITS-1:0]                  peak_volumes;
  logic [COUNT_BITS-1:0]                  least_volumes;

  modport source (
    output valid, group_key, group_years, group_match_total, group_volume_total,
           mean_year_by_match, mean_year_by_volume, latest_year, earliest_year,
           peak_matches, least_matches, peak_volumes, least_volumes,
    input  ready
  );
  modport sink (
    input  valid, group_key, group_years, group_match_total, group_volume_total,
           mean_year_by_match, mean_year_by_volume, latest_year, earliest_year,
           peak_matches, least_matches, peak_volumes, least_volumes,
    output ready
  );
endinterface

// ===== src/grs_mean_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_mean_div: weighted mean divider
// Restoring division of a weighted sum, scaled by the fraction bits, by a
// count sum, one quotient bit per cycle on one shared subtractor. The result
// clamps to all ones and is zero for a zero divisor.
// ----------------------------------------------------------------------------
module grs_mean_div import grs_pkg::*; #(
  parameter int YEAR_BITS          = 12,
  parameter int COUNT_BITS         = 32,
  parameter int MEAN_FRACTION_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [WSUM_BITS-1:0]                    dividend,
  input  logic [COUNT_BITS-1:0]                   divisor,
  output logic                                    done,
  output logic [YEAR_BITS+MEAN_FRACTION_BITS-1:0] quotient
);

  localparam int QW       = YEAR_BITS + MEAN_FRACTION_BITS;
  localparam int CW       = $clog2(QW);
  localparam int HI_SHIFT = YEAR_BITS + COUNT_BITS;

  div_state_t            state_r, state_nxt;
  logic [COUNT_BITS:0]   rem_r, rem_nxt;
  logic [QW-1:0]         sh_r, sh_nxt;
  logic [QW-1:0]         q_r, q_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] d_r, d_nxt;
  logic                  hi_nz_r, hi_nz_nxt;
  logic                  done_r, done_nxt;
  logic [QW-1:0]         quo_r, quo_nxt;

  logic [COUNT_BITS:0]   op_a;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic                  last_step;
  logic [WSUM_BITS-1:0]  hi_part;

  assign op_a      = (state_r == D_ITER) ? {rem_r[COUNT_BITS-1:0], sh_r[QW-1]} : rem_r;
  assign diff      = op_a - {1'b0, d_r};
  assign ge        = ~diff[COUNT_BITS];
  assign last_step = (cnt_r == CW'(QW - 1));
  assign hi_part   = dividend >> HI_SHIFT;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      D_IDLE: begin
        if (start && (divisor != '0)) begin
          state_nxt = D_CHECK;
        end
      end
      D_CHECK: begin
        if (hi_nz_r || ge) begin
          state_nxt = D_IDLE;
        end else begin
          state_nxt = D_ITER;
        end
      end
      D_ITER: begin
        if (last_step) begin
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    d_nxt     = d_r;
    hi_nz_nxt = hi_nz_r;
    done_nxt  = 1'b0;
    quo_nxt   = quo_r;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          d_nxt     = divisor;
          rem_nxt   = {1'b0, dividend[HI_SHIFT-1:YEAR_BITS]};
          sh_nxt    = QW'(dividend[YEAR_BITS-1:0]) << MEAN_FRACTION_BITS;
          hi_nz_nxt = |hi_part;
          q_nxt     = '0;
          cnt_nxt   = '0;
          if (divisor == '0) begin
            quo_nxt  = '0;
            done_nxt = 1'b1;
          end
        end
      end
      D_CHECK: begin
        if (hi_nz_r || ge) begin
          quo_nxt  = '1;
          done_nxt = 1'b1;
        end
      end
      D_ITER: begin
        rem_nxt = ge ? diff : op_a;
        q_nxt   = {q_r[QW-2:0], ge};
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (last_step) begin
          quo_nxt  = {q_r[QW-2:0], ge};
          done_nxt = 1'b1;
        end
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    rem_r   <= rem_nxt;
    sh_r    <= sh_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    d_r     <= d_nxt;
    hi_nz_r <= hi_nz_nxt;
    quo_r   <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == D_IDLE))
    else $error("divider reports done while still busy");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_ITER) |-> (rem_r < {1'b0, d_r}))
    else $error("partial remainder not below divisor");

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_IDLE && start && divisor == '0) |=> (done_r && quo_r == '0))
    else $error("zero divisor must give a zero mean");

endmodule

// ===== src/grouped_run_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_run_statistics: streaming group-by aggregate
// Running statistics over key-sorted records, at most one finished group per request.
// ----------------------------------------------------------------------------
// Records must arrive sorted by key. A record that extends or opens a group
// is multiplied in S_MUL_M and S_MUL_V by the single year-by-count multiplier
// that serves both weighted sums in turn, and is folded in at S_APPLY before
// the next ready. A record that closes a group first runs two weighted mean
// divisions on one shared restoring subtractor, one quotient bit per cycle,
// as does a flush of an open group. The finished group waits in an output
// register, so the next record is taken while it is pending; the block stalls
// only when a second group is ready before the first one is taken.
// ----------------------------------------------------------------------------
module grouped_run_statistics import grs_pkg::*; #(
  parameter int YEAR_BITS          = 12,
  parameter int COUNT_BITS         = 32,
  parameter int MEAN_FRACTION_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  grs_in_if.sink   in_ch,
  grs_out_if.source out_ch
);

  localparam int QW = YEAR_BITS + MEAN_FRACTION_BITS;
  localparam int PW = YEAR_BITS + COUNT_BITS;

  grs_state_t state_r, state_nxt;

  logic                  cmd_r;
  logic [KEY_BITS-1:0]   rkey_r;
  logic [YEAR_BITS-1:0]  y_r;
  logic [COUNT_BITS-1:0] m_r, v_r;
  logic                  emit_r, opening_r;

  logic                  open_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [COUNT_BITS-1:0] years_r, msum_r, vsum_r;
  logic [WSUM_BITS-1:0]  mws_r, vws_r;
  logic [YEAR_BITS-1:0]  yhi_r, ylo_r;
  logic [COUNT_BITS-1:0] mhi_r, mlo_r, vhi_r, vlo_r;

  logic [PW-1:0]         prod_r;
  logic [QW-1:0]         mean_m_r, mean_v_r;

  logic                  out_valid_r;
  logic [KEY_BITS-1:0]   o_key_r;
  logic [COUNT_BITS-1:0] o_years_r, o_msum_r, o_vsum_r;
  logic [QW-1:0]         o_mean_m_r, o_mean_v_r;
  logic [YEAR_BITS-1:0]  o_yhi_r, o_ylo_r;
  logic [COUNT_BITS-1:0] o_mhi_r, o_mlo_r, o_vhi_r, o_vlo_r;

  logic                  accept;
  logic                  key_differs;
  logic                  div_start;
  logic                  div_done;
  logic [QW-1:0]         div_quo;
  logic [WSUM_BITS-1:0]  div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                  out_free;
  logic                  load_out;
  logic [COUNT_BITS-1:0] mul_b;
  logic [PW-1:0]         prod_nxt;

  function automatic logic [COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [WSUM_BITS-1:0] sat_wsum(input logic [WSUM_BITS-1:0] a,
                                                    input logic [PW-1:0] b);
    logic [WSUM_BITS:0] s;
    s = {1'b0, a} + (WSUM_BITS + 1)'(b);
    return s[WSUM_BITS] ? '1 : s[WSUM_BITS-1:0];
  endfunction

  assign accept      = in_ch.valid && in_ch.ready;
  assign key_differs = (in_ch.record_key != key_r);
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (open_r && (in_ch.command == CMD_FLUSH || key_differs)) begin
            state_nxt = S_DIV_M;
          end else if (in_ch.command == CMD_FLUSH) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MUL_M;
          end
        end
      end
      S_DIV_M:  state_nxt = S_WAIT_M;
      S_WAIT_M: state_nxt = div_done ? S_DIV_V : S_WAIT_M;
      S_DIV_V:  state_nxt = S_WAIT_V;
      S_WAIT_V: state_nxt = div_done ? S_EMIT : S_WAIT_V;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = (cmd_r == CMD_FLUSH) ? S_IDLE : S_MUL_M;
        end
      end
      S_MUL_M:  state_nxt = S_MUL_V;
      S_MUL_V:  state_nxt = S_APPLY;
      S_APPLY:  state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      S_IDLE:  in_ch.ready = 1'b1;
      S_DIV_M: div_start   = 1'b1;
      S_DIV_V: div_start   = 1'b1;
      S_EMIT:  load_out    = out_free;
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign div_dividend = (state_r == S_DIV_V || state_r == S_WAIT_V) ? vws_r : mws_r;
  assign div_divisor  = (state_r == S_DIV_V || state_r == S_WAIT_V) ? vsum_r : msum_r;

  grs_mean_div #(
    .YEAR_BITS          (YEAR_BITS),
    .COUNT_BITS         (COUNT_BITS),
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign mul_b    = (state_r == S_MUL_M) ? m_r : v_r;
  assign prod_nxt = PW'(y_r) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_ch.command;
      rkey_r    <= in_ch.record_key;
      y_r       <= in_ch.record_year;
      m_r       <= in_ch.record_matches;
      v_r       <= in_ch.record_volumes;
      emit_r    <= open_r && (in_ch.command == CMD_FLUSH || key_differs);
      opening_r <= !open_r || key_differs;
    end
    if (state_r == S_MUL_M || state_r == S_MUL_V) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_WAIT_M && div_done) begin
      mean_m_r <= div_quo;
    end
    if (state_r == S_WAIT_V && div_done) begin
      mean_v_r <= div_quo;
    end
    if (load_out) begin
      o_key_r    <= key_r;
      o_years_r  <= years_r;
      o_msum_r   <= msum_r;
      o_vsum_r   <= vsum_r;
      o_mean_m_r <= mean_m_r;
      o_mean_v_r <= mean_v_r;
      o_yhi_r    <= yhi_r;
      o_ylo_r    <= ylo_r;
      o_mhi_r    <= mhi_r;
      o_mlo_r    <= mlo_r;
      o_vhi_r    <= vhi_r;
      o_vlo_r    <= vlo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      open_r      <= 1'b0;
      key_r       <= '0;
      years_r     <= '0;
      msum_r      <= '0;
      vsum_r      <= '0;
      mws_r       <= '0;
      vws_r       <= '0;
      yhi_r       <= '0;
      ylo_r       <= '0;
      mhi_r       <= '0;
      mlo_r       <= '0;
      vhi_r       <= '0;
      vlo_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_out && cmd_r == CMD_FLUSH) begin
        open_r  <= 1'b0;
        key_r   <= '0;
        years_r <= '0;
        msum_r  <= '0;
        vsum_r  <= '0;
        mws_r   <= '0;
        vws_r   <= '0;
        yhi_r   <= '0;
        ylo_r   <= '0;
        mhi_r   <= '0;
        mlo_r   <= '0;
        vhi_r   <= '0;
        vlo_r   <= '0;
      end
      if (state_r == S_MUL_V) begin
        mws_r <= opening_r ? WSUM_BITS'(prod_r) : sat_wsum(mws_r, prod_r);
      end
      if (state_r == S_APPLY) begin
        vws_r <= opening_r ? WSUM_BITS'(prod_r) : sat_wsum(vws_r, prod_r);
        if (opening_r) begin
          open_r  <= 1'b1;
          key_r   <= rkey_r;
          years_r <= COUNT_BITS'(1);
          msum_r  <= m_r;
          vsum_r  <= v_r;
          yhi_r   <= y_r;
          ylo_r   <= y_r;
          mhi_r   <= m_r;
          mlo_r   <= m_r;
          vhi_r   <= v_r;
          vlo_r   <= v_r;
        end else begin
          years_r <= sat_count(years_r, COUNT_BITS'(1));
          msum_r  <= sat_count(msum_r, m_r);
          vsum_r  <= sat_count(vsum_r, v_r);
          if (y_r > yhi_r) yhi_r <= y_r;
          if (y_r < ylo_r) ylo_r <= y_r;
          if (m_r > mhi_r) mhi_r <= m_r;
          if (m_r < mlo_r) mlo_r <= m_r;
          if (v_r > vhi_r) vhi_r <= v_r;
          if (v_r < vlo_r) vlo_r <= v_r;
        end
      end
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.group_key           = o_key_r;
  assign out_ch.group_years         = o_years_r;
  assign out_ch.group_match_total   = o_msum_r;
  assign out_ch.group_volume_total  = o_vsum_r;
  assign out_ch.mean_year_by_match  = o_mean_m_r;
  assign out_ch.mean_year_by_volume = o_mean_v_r;
  assign out_ch.latest_year         = o_yhi_r;
  assign out_ch.earliest_year       = o_ylo_r;
  assign out_ch.peak_matches        = o_mhi_r;
  assign out_ch.least_matches       = o_mlo_r;
  assign out_ch.peak_volumes        = o_vhi_r;
  assign out_ch.least_volumes       = o_vlo_r;

  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    open_r == (years_r != '0))
    else $error("open group flag disagrees with record count");

  a_year_order: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (ylo_r <= yhi_r))
    else $error("earliest year above latest year");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (mlo_r <= mhi_r && vlo_r <= vhi_r))
    else $error("count minimum above count maximum");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("finished group not presented");

  a_emit_only_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_M) |-> (open_r && emit_r))
    else $error("group closed while none is open");

endmodule

// ===== test/grouped_run_statistics_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_run_statistics_tb: self-checking bench for the group-by aggregate
// Drives a table of directed record and flush requests, then a long stream of
// key-sorted runs mixed with noise and flushes. Both channels idle and stall
// at random, and the group channel holds off once for a long stretch. Every
// finished group is compared field by field against a predictor in the bench
// or, for some directed rows, against a group given in the table.
module grouped_run_statistics_tb;
  import grs_pkg::*;

  localparam int YEAR_BITS    = 12;
  localparam int COUNT_BITS   = 32;
  localparam int FRAC_BITS    = 8;
  localparam int MEAN_BITS    = YEAR_BITS + FRAC_BITS;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_FROM   = 1200;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic                  command;
    logic [KEY_BITS-1:0]   key;
    logic [YEAR_BITS-1:0]  year;
    logic [COUNT_BITS-1:0] match_count;
    logic [COUNT_BITS-1:0] volumes;
  } record_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] years;
    logic [COUNT_BITS-1:0] match_total;
    logic [COUNT_BITS-1:0] volume_total;
    logic [MEAN_BITS-1:0]  mean_by_match;
    logic [MEAN_BITS-1:0]  mean_by_volume;
    logic [YEAR_BITS-1:0]  latest;
    logic [YEAR_BITS-1:0]  earliest;
    logic [COUNT_BITS-1:0] peak_matches;
    logic [COUNT_BITS-1:0] least_matches;
    logic [COUNT_BITS-1:0] peak_volumes;
    logic [COUNT_BITS-1:0] least_volumes;
  } group_t;

  typedef struct packed {
    bit      typed;
    record_t rec;
    group_t  grp;
  } plan_row_t;

  logic clk;
  logic rst_n;

  grs_in_if  #(.YEAR_BITS(YEAR_BITS), .COUNT_BITS(COUNT_BITS)) in_ch ();
  grs_out_if #(.YEAR_BITS(YEAR_BITS), .COUNT_BITS(COUNT_BITS),
               .MEAN_FRACTION_BITS(FRAC_BITS)) out_ch ();

  grouped_run_statistics #(
    .YEAR_BITS(YEAR_BITS),
    .COUNT_BITS(COUNT_BITS),
    .MEAN_FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Running state of the open group, as the block should hold it.
  bit                    grp_open;
  logic [KEY_BITS-1:0]   grp_key;
  logic [COUNT_BITS-1:0] grp_count;
  logic [COUNT_BITS-1:0] grp_match_sum;
  logic [COUNT_BITS-1:0] grp_volume_sum;
  logic [WSUM_BITS-1:0]  grp_match_wsum;
  logic [WSUM_BITS-1:0]  grp_volume_wsum;
  logic [YEAR_BITS-1:0]  grp_year_hi;
  logic [YEAR_BITS-1:0]  grp_year_lo;
  logic [COUNT_BITS-1:0] grp_match_hi;
  logic [COUNT_BITS-1:0] grp_match_lo;
  logic [COUNT_BITS-1:0] grp_volume_hi;
  logic [COUNT_BITS-1:0] grp_volume_lo;

  group_t              pending_groups[$];
  group_t              oldest_group;
  plan_row_t           directed_plan[$];
  plan_row_t           tail_row;
  int                  fail_count;
  bit                  quiet;
  bit                  hold_req;
  bit                  hold_served;
  logic [KEY_BITS-1:0] run_key_base;
  int                  run_left;

  function automatic logic [COUNT_BITS-1:0] add_count(logic [COUNT_BITS-1:0] a,
                                                      logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [WSUM_BITS-1:0] add_wsum(logic [WSUM_BITS-1:0] a,
                                                    logic [WSUM_BITS-1:0] b);
    logic [WSUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WSUM_BITS] ? '1 : s[WSUM_BITS-1:0];
  endfunction

  function automatic logic [MEAN_BITS-1:0] mean_of(logic [WSUM_BITS-1:0] wsum,
                                                  logic [COUNT_BITS-1:0] divisor);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] v;
    if (divisor == 0) return '0;
    q = wsum / 64'(divisor);
    r = wsum % 64'(divisor);
    if (q > 64'((1 << YEAR_BITS) - 1)) return '1;
    v = (q << FRAC_BITS) | ((r << FRAC_BITS) / 64'(divisor));
    return (v > 64'((1 << MEAN_BITS) - 1)) ? '1 : v[MEAN_BITS-1:0];
  endfunction

  // Applies one request to the group state; returns 1 when a group finishes.
  function automatic bit absorb_record(input record_t r, output group_t g);
    logic [WSUM_BITS-1:0] m_prod;
    logic [WSUM_BITS-1:0] v_prod;
    bit                   done;
    m_prod = 64'(r.year) * 64'(r.match_count);
    v_prod = 64'(r.year) * 64'(r.volumes);
    g.key            = grp_key;
    g.years          = grp_count;
    g.match_total    = grp_match_sum;
    g.volume_total   = grp_volume_sum;
    g.mean_by_match  = mean_of(grp_match_wsum, grp_match_sum);
    g.mean_by_volume = mean_of(grp_volume_wsum, grp_volume_sum);
    g.latest         = grp_year_hi;
    g.earliest       = grp_year_lo;
    g.peak_matches   = grp_match_hi;
    g.least_matches  = grp_match_lo;
    g.peak_volumes   = grp_volume_hi;
    g.least_volumes  = grp_volume_lo;
    done = 1'b0;
    if (r.command == CMD_FLUSH) begin
      done     = grp_open;
      grp_open = 1'b0;
    end else if (!grp_open || r.key != grp_key) begin
      done            = grp_open;
      grp_open        = 1'b1;
      grp_key         = r.key;
      grp_count       = 1;
      grp_match_sum   = r.match_count;
      grp_volume_sum  = r.volumes;
      grp_match_wsum  = m_prod;
      grp_volume_wsum = v_prod;
      grp_year_hi     = r.year;
      grp_year_lo     = r.year;
      grp_match_hi    = r.match_count;
      grp_match_lo    = r.match_count;
      grp_volume_hi   = r.volumes;
      grp_volume_lo   = r.volumes;
    end else begin
      grp_count       = add_count(grp_count, 1);
      grp_match_sum   = add_count(grp_match_sum, r.match_count);
      grp_volume_sum  = add_count(grp_volume_sum, r.volumes);
      grp_match_wsum  = add_wsum(grp_match_wsum, m_prod);
      grp_volume_wsum = add_wsum(grp_volume_wsum, v_prod);
      if (r.year > grp_year_hi) grp_year_hi = r.year;
      if (r.year < grp_year_lo) grp_year_lo = r.year;
      if (r.match_count > grp_match_hi) grp_match_hi = r.match_count;
      if (r.match_count < grp_match_lo) grp_match_lo = r.match_count;
      if (r.volumes > grp_volume_hi) grp_volume_hi = r.volumes;
      if (r.volumes < grp_volume_lo) grp_volume_lo = r.volumes;
    end
    return done;
  endfunction

  function automatic plan_row_t row(logic cmd, logic [KEY_BITS-1:0] key,
                                    logic [YEAR_BITS-1:0] year,
                                    logic [COUNT_BITS-1:0] match_count,
                                    logic [COUNT_BITS-1:0] volumes,
                                    bit typed = 1'b0, group_t grp = '0);
    plan_row_t p;
    p.typed           = typed;
    p.rec.command     = cmd;
    p.rec.key         = key;
    p.rec.year        = year;
    p.rec.match_count = match_count;
    p.rec.volumes     = volumes;
    p.grp             = grp;
    return p;
  endfunction

  function automatic group_t single_group(logic [KEY_BITS-1:0] key,
                                          logic [YEAR_BITS-1:0] year,
                                          logic [COUNT_BITS-1:0] match_count,
                                          logic [COUNT_BITS-1:0] volumes,
                                          logic [MEAN_BITS-1:0] mean_m,
                                          logic [MEAN_BITS-1:0] mean_v);
    group_t g;
    g.key            = key;
    g.years          = 1;
    g.match_total    = match_count;
    g.volume_total   = volumes;
    g.mean_by_match  = mean_m;
    g.mean_by_volume = mean_v;
    g.latest         = year;
    g.earliest       = year;
    g.peak_matches   = match_count;
    g.least_matches  = match_count;
    g.peak_volumes   = volumes;
    g.least_volumes  = volumes;
    return g;
  endfunction

  function automatic logic [COUNT_BITS-1:0] random_count();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return $urandom;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // Mostly sorted runs of one key; some flushes and some stray keys.
  function automatic record_t random_record();
    record_t r;
    int      pick;
    pick          = $urandom_range(0, 99);
    r.command     = CMD_RECORD;
    r.year        = ($urandom_range(0, 3) == 0)
                    ? YEAR_BITS'($urandom_range(0, (1 << YEAR_BITS) - 1))
                    : YEAR_BITS'($urandom_range(1500, 2020));
    r.match_count = random_count();
    r.volumes     = random_count();
    if (pick < 5) begin
      r.command = CMD_FLUSH;
      r.key     = {$urandom, $urandom};
    end else if (pick < 11) begin
      case ($urandom_range(0, 3))
        0: r.key = '0;
        1: r.key = '1;
        default: r.key = {$urandom, $urandom};
      endcase
    end else begin
      if (run_left == 0) begin
        run_key_base = run_key_base + KEY_BITS'($urandom_range(1, 1000));
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      end
      run_left--;
      r.key = run_key_base;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic offer(input record_t r, input bit typed, input group_t typed_grp);
    group_t predicted;
    bit     emits;
    in_ch.valid          <= 1'b1;
    in_ch.command        <= r.command;
    in_ch.record_key     <= r.key;
    in_ch.record_year    <= r.year;
    in_ch.record_matches <= r.match_count;
    in_ch.record_volumes <= r.volumes;
    do @(posedge clk); while (!in_ch.ready);
    emits = absorb_record(r, predicted);
    if (typed) pending_groups.push_back(typed_grp);
    else if (emits) pending_groups.push_back(predicted);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_groups.size() == 0) begin
        $error("group_key: expected no group, got %0h", out_ch.group_key);
        fail_count++;
      end else begin
        oldest_group = pending_groups.pop_front();
        check_field("group_key", oldest_group.key, out_ch.group_key);
        check_field("group_years", oldest_group.years, out_ch.group_years);
        check_field("group_match_total", oldest_group.match_total, out_ch.group_match_total);
        check_field("group_volume_total", oldest_group.volume_total,
                    out_ch.group_volume_total);
        check_field("mean_year_by_match", oldest_group.mean_by_match,
                    out_ch.mean_year_by_match);
        check_field("mean_year_by_volume", oldest_group.mean_by_volume,
                    out_ch.mean_year_by_volume);
        check_field("latest_year", oldest_group.latest, out_ch.latest_year);
        check_field("earliest_year", oldest_group.earliest, out_ch.earliest_year);
        check_field("peak_matches", oldest_group.peak_matches, out_ch.peak_matches);
        check_field("least_matches", oldest_group.least_matches, out_ch.least_matches);
        check_field("peak_volumes", oldest_group.peak_volumes, out_ch.peak_volumes);
        check_field("least_volumes", oldest_group.least_volumes, out_ch.least_volumes);
      end
    end
  end

  // The group channel stalls in short bursts and once for a long stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL grouped_run_statistics");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_RECORD;
    in_ch.record_key     = '0;
    in_ch.record_year    = '0;
    in_ch.record_matches = '0;
    in_ch.record_volumes = '0;
    fail_count           = 0;
    quiet                = 1'b0;
    hold_req             = 1'b0;
    hold_served          = 1'b0;
    grp_open             = 1'b0;
    run_left             = 0;
    run_key_base         = {$urandom, $urandom};

    directed_plan.push_back(row(CMD_FLUSH, 64'd0, 12'd0, 32'd0, 32'd0));
    directed_plan.push_back(row(CMD_RECORD, 64'd0, 12'd0, 32'd0, 32'd0));
    directed_plan.push_back(row(CMD_FLUSH, 64'd0, 12'd0, 32'd0, 32'd0, 1'b1,
                                single_group(64'd0, 12'd0, 32'd0, 32'd0, '0, '0)));
    directed_plan.push_back(row(CMD_RECORD, '1, '1, '1, '1));
    directed_plan.push_back(row(CMD_FLUSH, 64'd0, 12'd0, 32'd0, 32'd0, 1'b1,
                                single_group('1, '1, '1, '1, 20'hFFF00, 20'hFFF00)));
    directed_plan.push_back(row(CMD_FLUSH, 64'hDEAD, 12'd99, 32'd5, 32'd6));
    directed_plan.push_back(row(CMD_RECORD, 64'd5, 12'd1900, 32'd10, 32'd3));
    directed_plan.push_back(row(CMD_RECORD, 64'd5, 12'd2000, 32'd0, 32'd7));
    directed_plan.push_back(row(CMD_RECORD, 64'd5, 12'd1950, '1, 32'd1));
    directed_plan.push_back(row(CMD_RECORD, 64'd5, '1, '1, 32'd0));
    directed_plan.push_back(row(CMD_RECORD, 64'd6, 12'd0, 32'd1, 32'd1));
    directed_plan.push_back(row(CMD_RECORD, 64'd6, '1, 32'd0, 32'd0));
    directed_plan.push_back(row(CMD_RECORD, 64'd3, 12'd100, 32'd1, 32'd0));
    directed_plan.push_back(row(CMD_RECORD, 64'd3, 12'd50, 32'd0, 32'd0));
    directed_plan.push_back(row(CMD_RECORD, 64'd8, 12'd3, 32'd2, 32'd0));
    directed_plan.push_back(row(CMD_RECORD, 64'd8, 12'd4, 32'd1, 32'd5));
    directed_plan.push_back(row(CMD_RECORD, 64'd0, 12'd7, 32'd0, 32'd0));
    directed_plan.push_back(row(CMD_RECORD, 64'd9, 12'd2023, 32'd7, 32'd9));
    directed_plan.push_back(row(CMD_FLUSH, 64'hABC, 12'd12, 32'd34, 32'd56, 1'b1,
                                single_group(64'd9, 12'd2023, 32'd7, 32'd9,
                                             20'h7E700, 20'h7E700)));
    directed_plan.push_back(row(CMD_RECORD, '1, 12'd0, 32'd0, 32'd0));
    directed_plan.push_back(row(CMD_RECORD, '1, '1, '1, '1));
    directed_plan.push_back(row(CMD_RECORD, 64'd1, 12'd1, 32'd1, 32'd1));
    directed_plan.push_back(row(CMD_FLUSH, '1, '1, '1, '1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i])
      offer(directed_plan[i].rec, directed_plan[i].typed, directed_plan[i].grp);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == QUIET_FROM) quiet = 1'b1;
      offer(random_record(), 1'b0, '0);
    end
    tail_row = row(CMD_FLUSH, '0, '0, '0, '0);
    offer(tail_row.rec, 1'b0, '0);
    in_ch.valid <= 1'b0;

    while (pending_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS grouped_run_statistics");
    end else begin
      $display("FAIL grouped_run_statistics");
    end
    $finish;
  end

endmodule
